// ===== rtl/core/mma_pkg.sv =====
`timescale 1ns / 1ps

package mma_pkg;

    // Field widths of the request and result streams.
    localparam int JOINT_W  = 4;
    localparam int QTY_W    = 2;
    localparam int SAMPLE_W = 32;
    localparam int USER_W   = JOINT_W + QTY_W;
    localparam int WINDOW_W = 6;

    // Defaults for the top-level parameters.
    localparam int JOINTS_DEFAULT     = 16;
    localparam int WINDOW_MAX_DEFAULT = 32;

    localparam logic [WINDOW_W-1:0] WINDOW_LENGTH_RESET = WINDOW_W'(5);

    // Quantity codes carried in tuser.
    localparam logic [QTY_W-1:0] QTY_POSITION = 2'd0;
    localparam logic [QTY_W-1:0] QTY_VELOCITY = 2'd1;
    localparam logic [QTY_W-1:0] QTY_EFFORT   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATE_RD,
        ST_STATE_LATCH,
        ST_RING_RD,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIVIDE,
        ST_OUTPUT
    } mma_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mma_div_status_t;

endpackage

// ===== rtl/core/mma_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module mma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mma_div.sv =====
`timescale 1ns / 1ps

// Signed by unsigned divider, one restoring step per cycle, quotient
// truncated toward zero and cut to QUOT_W bits.
module mma_div
    import mma_pkg::*;
#(
    parameter int DIVIDEND_W = 37,
    parameter int DIVISOR_W  = 6,
    parameter int QUOT_W     = 32
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output mma_div_status_t              status,
    output logic        [QUOT_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic                  neg_reg, neg_next;
    logic [QUOT_W-1:0]     result_reg, result_next;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;
    logic [QUOT_W-1:0]     quot_trunc;

    assign rem_shift  = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign rem_diff   = rem_shift - {1'b0, divisor_reg};
    assign fits       = rem_shift >= {1'b0, divisor_reg};
    assign quot_trunc = quot_reg[QUOT_W-1:0];

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        result_next  = result_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(DIVIDEND_W);
            neg_next     = dividend[DIVIDEND_W-1];
            quot_next    = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend)
                                                  : DIVIDEND_W'(dividend);
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                quot_next = {quot_reg[DIVIDEND_W-2:0], fits};
                rem_next  = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            else
            begin
                // Magnitude is done; restore the sign of the dividend.
                result_next = neg_reg ? (~quot_trunc + QUOT_W'(1)) : quot_trunc;
                busy_next   = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        result_reg  <= result_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = result_reg;

endmodule

// ===== rtl/core/multichannel_moving_average_core.sv =====
`timescale 1ns / 1ps

// Per-channel boxcar moving average. A channel is one joint together with
// one quantity (position, velocity or effort), giving 3*JOINTS channels.
// Each request on the slave stream carries one signed Q16.16 sample, with
// the joint and quantity in tuser; the block appends it to that channel's
// ring, updates the channel's running sum and returns one result with the
// running sum divided by the channel's fill count, truncated toward zero.
// While a ring warms up, the mean is over fewer samples. window_length,
// written through cfg_we/cfg_wdata, sets how many recent samples are
// averaged; zero acts as one and values above WINDOW_MAX act as
// WINDOW_MAX. The user must write window_length only while the block is
// idle; the block itself does not enforce this. Shrinking the window never
// shrinks a channel's fill: a full channel keeps its larger fill. Requests
// with quantity three or a joint at or above JOINTS are consumed in the
// idle state and produce no result. One request is worked on at a time:
// after an accepted request the block takes no new one until it has read
// the channel state and ring, updated them, divided the running sum by the
// fill count in the bit-serial divider and placed the result in the output
// register. A finished result waits in the output register, so the next
// request is accepted while it is pending.
// No clearing pass is needed after reset.
module multichannel_moving_average_core
    import mma_pkg::*;
#(
    parameter int JOINTS     = JOINTS_DEFAULT,
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample_value
    input  logic [USER_W-1:0]   s_tuser,   // [3:0] joint_index, [5:4] quantity
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,   // [31:0] average_value
    output logic [USER_W-1:0]   m_tuser,   // [3:0] out_joint_index, [5:4] out_quantity
    input  logic                cfg_we,
    input  logic [WINDOW_W-1:0] cfg_wdata  // window_length
);

    localparam int CHANNELS   = 3 * JOINTS;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_MAX);
    localparam int STATE_W    = SUM_W + FILL_W + PTR_W;
    localparam int RING_DEPTH = CHANNELS * WINDOW_MAX;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // Sequencer and configuration.
    mma_state_t state_reg, state_next;
    logic [WINDOW_W-1:0] window_reg, window_next;
    logic [FILL_W-1:0]   win_eff;

    // The request being worked on.
    logic [JOINT_W-1:0]         joint_reg, joint_next;
    logic [QTY_W-1:0]           qty_reg, qty_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [CH_W-1:0]            ch_reg, ch_next;

    // Working copy of the channel state.
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic                    full_reg, full_next;

    // A channel whose state word was never written reads as all zero.
    logic [CHANNELS-1:0] chan_valid_reg, chan_valid_next;

    // Output register.
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0] m_tdata_reg, m_tdata_next;
    logic [USER_W-1:0]   m_tuser_reg, m_tuser_next;

    // Request decode.
    logic [JOINT_W-1:0]  in_joint;
    logic [QTY_W-1:0]    in_qty;
    logic [CH_W-1:0]     in_ch;
    logic                item_ok;
    logic                in_accept;

    // Memory ports and datapath.
    logic                       state_re, state_we;
    logic [STATE_W-1:0]         state_rdata, state_wdata;
    logic signed [SUM_W-1:0]    rd_sum;
    logic [FILL_W-1:0]          rd_fill;
    logic [PTR_W-1:0]           rd_ptr;
    logic                       ring_re, ring_we;
    logic [RING_AW-1:0]         ring_addr;
    logic [PTR_W-1:0]           ring_slot;
    logic signed [SAMPLE_W-1:0] ring_rdata;
    logic signed [SAMPLE_W-1:0] dropped;
    logic                       full_now;
    logic [FILL_W:0]            slot_sum;
    logic [PTR_W-1:0]           oldest;
    logic signed [SUM_W-1:0]    new_sum;
    logic [FILL_W-1:0]          new_fill;
    logic [PTR_W-1:0]           new_ptr;

    // Divider.
    logic                div_start;
    mma_div_status_t     div_status;
    logic [SAMPLE_W-1:0] div_quotient;
    logic                out_load;

    assign in_joint  = s_tuser[JOINT_W-1:0];
    assign in_qty    = s_tuser[USER_W-1:JOINT_W];
    assign in_ch     = CH_W'(in_qty) * CH_W'(JOINTS) + CH_W'(in_joint);
    assign item_ok   = (int'(in_joint) < JOINTS) && (in_qty <= QTY_EFFORT);
    assign in_accept = s_tvalid && s_tready;

    // Effective window: zero acts as one, large values saturate.
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = FILL_W'(1);
        end
        else if (int'(window_reg) > WINDOW_MAX)
        begin
            win_eff = FILL_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = FILL_W'(window_reg);
        end
    end

    assign rd_sum  = state_rdata[STATE_W-1 -: SUM_W];
    assign rd_fill = state_rdata[PTR_W +: FILL_W];
    assign rd_ptr  = state_rdata[PTR_W-1:0];

    // The channel drops its oldest sample once it holds a full window.
    // The oldest slot lies fill entries behind the write pointer, modulo
    // the ring length; one compare and subtract covers the wrap.
    assign full_now = fill_reg >= win_eff;
    assign slot_sum = (FILL_W+1)'(ptr_reg) + (FILL_W+1)'(WINDOW_MAX)
                      - (FILL_W+1)'(fill_reg);
    assign oldest   = (slot_sum >= (FILL_W+1)'(WINDOW_MAX))
                      ? PTR_W'(slot_sum - (FILL_W+1)'(WINDOW_MAX))
                      : PTR_W'(slot_sum);

    // The ring is read at the oldest slot and later written at the pointer.
    assign ring_slot = (state_reg == ST_RING_RD) ? oldest : ptr_reg;
    assign ring_addr = RING_AW'(ch_reg) * RING_AW'(WINDOW_MAX) + RING_AW'(ring_slot);

    assign dropped  = full_reg ? ring_rdata : '0;
    assign new_sum  = sum_reg - SUM_W'(dropped) + SUM_W'(sample_reg);
    assign new_fill = full_reg ? fill_reg : fill_reg + FILL_W'(1);
    assign new_ptr  = (ptr_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_reg + PTR_W'(1);

    assign state_wdata = {new_sum, new_fill, new_ptr};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && item_ok)
                begin
                    state_next = ST_STATE_RD;
                end
            end
            ST_STATE_RD:    state_next = ST_STATE_LATCH;
            ST_STATE_LATCH: state_next = ST_RING_RD;
            ST_RING_RD:     state_next = ST_UPDATE;
            ST_UPDATE:      state_next = ST_DIV_START;
            ST_DIV_START:   state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready  = 1'b0;
        state_re  = 1'b0;
        state_we  = 1'b0;
        ring_re   = 1'b0;
        ring_we   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:      s_tready  = 1'b1;
            ST_STATE_RD:  state_re  = 1'b1;
            ST_RING_RD:   ring_re   = full_now;
            ST_UPDATE:
            begin
                state_we = 1'b1;
                ring_we  = 1'b1;
            end
            ST_DIV_START: div_start = 1'b1;
            ST_OUTPUT:    out_load  = !m_tvalid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        window_next     = cfg_we ? cfg_wdata : window_reg;
        joint_next      = joint_reg;
        qty_next        = qty_reg;
        sample_next     = sample_reg;
        ch_next         = ch_reg;
        sum_next        = sum_reg;
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        full_next       = full_reg;
        chan_valid_next = chan_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (in_accept)
        begin
            joint_next  = in_joint;
            qty_next    = in_qty;
            sample_next = s_tdata;
            ch_next     = in_ch;
        end

        if (state_reg == ST_STATE_LATCH)
        begin
            if (chan_valid_reg[ch_reg])
            begin
                sum_next  = rd_sum;
                fill_next = rd_fill;
                ptr_next  = rd_ptr;
            end
            else
            begin
                sum_next  = '0;
                fill_next = '0;
                ptr_next  = '0;
            end
        end

        if (state_reg == ST_RING_RD)
        begin
            full_next = full_now;
        end

        if (state_we)
        begin
            sum_next                = new_sum;
            fill_next               = new_fill;
            chan_valid_next[ch_reg] = 1'b1;
        end

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = div_quotient;
            m_tuser_next  = {qty_reg, joint_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_reg     <= WINDOW_LENGTH_RESET;
            chan_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_reg     <= window_next;
            chan_valid_reg <= chan_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        joint_reg   <= joint_next;
        qty_reg     <= qty_next;
        sample_reg  <= sample_next;
        ch_reg      <= ch_next;
        sum_reg     <= sum_next;
        fill_reg    <= fill_next;
        ptr_reg     <= ptr_next;
        full_reg    <= full_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Per-channel running sum, fill count and write pointer.
    mma_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS),
        .AW    (CH_W)
    ) u_state_ram (
        .clk   (clk),
        .we    (state_we),
        .waddr (ch_reg),
        .wdata (state_wdata),
        .re    (state_re),
        .raddr (ch_reg),
        .rdata (state_rdata)
    );

    // Sample rings, WINDOW_MAX slots per channel.
    mma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH),
        .AW    (RING_AW)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_addr),
        .wdata (sample_reg),
        .re    (ring_re),
        .raddr (ring_addr),
        .rdata (ring_rdata)
    );

    mma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (FILL_W),
        .QUOT_W     (SAMPLE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // The divider is only started when it has finished the previous request.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    // A finished division is always collected by the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("division finished outside the divide state");

    // The written fill count is never zero and never exceeds the ring length.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_we |-> ((new_fill != '0) && (int'(new_fill) <= WINDOW_MAX)))
        else $error("fill count out of range");

    // A channel written once reads back from memory afterwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_we |=> chan_valid_reg[$past(ch_reg)])
        else $error("channel not marked as written");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the multichannel moving average core.
// Requests are driven on the slave stream at the falling edge and results are
// sampled on the master stream at the rising edge. A behavioral copy of the
// per-channel rings, running sums and fill counts predicts every result.
// The checker compares each result with the oldest prediction.
module tb_top;
    import mma_pkg::*;

    localparam int CHANNELS       = 3 * JOINTS_DEFAULT;
    localparam int IDLE_SETTLE    = 60;   // longer than the core takes for one request
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 250;
    localparam int HOT_CHANNELS   = 3;
    localparam int PENDING_DEPTH  = 16;

    // The fourth quantity code is not a real quantity; the core drops it.
    localparam logic [QTY_W-1:0] QTY_UNUSED = 2'd3;

    typedef struct packed {
        logic [JOINT_W-1:0]         joint;
        logic [QTY_W-1:0]           quantity;
        logic signed [SAMPLE_W-1:0] average;
    } average_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [SAMPLE_W-1:0] s_tdata;    // [31:0] sample_value
    logic [USER_W-1:0] s_tuser;      // [3:0] joint_index, [5:4] quantity
    logic m_tvalid;
    logic m_tready;
    logic [SAMPLE_W-1:0] m_tdata;    // [31:0] average_value
    logic [USER_W-1:0] m_tuser;      // [3:0] out_joint_index, [5:4] out_quantity
    logic cfg_we;
    logic [WINDOW_W-1:0] cfg_wdata;

    // Shadow state of the core: one ring, sum, fill count and write slot per channel.
    logic signed [SAMPLE_W-1:0] shadow_ring [CHANNELS][WINDOW_MAX_DEFAULT];
    longint shadow_sum [CHANNELS];
    int shadow_fill [CHANNELS];
    int shadow_slot [CHANNELS];
    logic [WINDOW_W-1:0] shadow_window;

    // Predicted results in order of acceptance, kept in a small ring. The
    // sender only advances the tail and the checker only advances the head.
    average_result_t pending_averages [PENDING_DEPTH];
    int pending_head;
    int pending_tail;

    int error_count;
    int requests_sent;
    int requests_dropped;
    int averages_checked;
    int receiver_hold_cycles;
    bit sender_no_gaps;
    bit receiver_no_gaps;
    logic [JOINT_W-1:0] hot_joint [HOT_CHANNELS];
    logic [QTY_W-1:0] hot_quantity [HOT_CHANNELS];

    multichannel_moving_average_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pending_count();
        return pending_tail - pending_head;
    endfunction

    function automatic void store_expected(input average_result_t entry);
        pending_averages[pending_tail % PENDING_DEPTH] = entry;
        pending_tail++;
    endfunction

    function automatic average_result_t take_expected();
        average_result_t entry;
        entry = pending_averages[pending_head % PENDING_DEPTH];
        pending_head++;
        return entry;
    endfunction

    // Idle lengths: mostly none, sometimes a few cycles, rarely a long pause.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Sample values lean on the extremes of Q16.16 so that the running sums
    // reach their widest values and truncation of negative means is exercised.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return SAMPLE_W'($urandom_range(0, 7)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    // Applies one sample to the shadow state and returns the mean that the
    // core must report. Returns 0 for requests the core drops without a result.
    function automatic bit predict_channel_average(input logic [JOINT_W-1:0] joint,
                                                   input logic [QTY_W-1:0] quantity,
                                                   input logic signed [SAMPLE_W-1:0] sample,
                                                   output average_result_t result);
        int window;
        int ch;
        int slot;
        int fill;
        int oldest;
        longint mean;
        result = '0;
        if (quantity == QTY_UNUSED || int'(joint) >= JOINTS_DEFAULT)
            return 1'b0;
        // Zero acts as one; anything above the ring depth acts as the ring depth.
        window = int'(shadow_window);
        if (window == 0)
            window = 1;
        if (window > WINDOW_MAX_DEFAULT)
            window = WINDOW_MAX_DEFAULT;
        ch = int'(quantity) * JOINTS_DEFAULT + int'(joint);
        slot = shadow_slot[ch];
        fill = shadow_fill[ch];
        // A channel at or above the window drops its oldest sample; the fill never
        // shrinks, even when the window has been made smaller.
        if (fill >= window && fill > 0)
        begin
            oldest = (slot + WINDOW_MAX_DEFAULT - fill) % WINDOW_MAX_DEFAULT;
            shadow_sum[ch] -= longint'(shadow_ring[ch][oldest]);
        end
        else
        begin
            fill++;
        end
        shadow_ring[ch][slot] = sample;
        shadow_sum[ch] += longint'(sample);
        shadow_slot[ch] = (slot + 1) % WINDOW_MAX_DEFAULT;
        shadow_fill[ch] = fill;
        mean = shadow_sum[ch] / longint'(fill);
        result.joint = joint;
        result.quantity = quantity;
        result.average = mean[SAMPLE_W-1:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint expected_value,
                                   input longint actual_value);
        $display("[%0t] mismatch in %s: expected %0h, got %0h", $realtime, what,
                 expected_value, actual_value);
        error_count++;
    endtask

    // Offers one request, with an optional idle gap before it, and records the
    // predicted result once the request has been accepted.
    task automatic send_request(input logic [JOINT_W-1:0] joint,
                                input logic [QTY_W-1:0] quantity,
                                input logic [SAMPLE_W-1:0] sample);
        int gap;
        average_result_t predicted;
        gap = sender_no_gaps ? 0 : idle_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        s_tuser <= {quantity, joint};
        do
            @(posedge clk);
        while (!s_tready);
        if (predict_channel_average(joint, quantity, sample, predicted))
        begin
            if (pending_count() >= PENDING_DEPTH)
                report_mismatch("requests in flight", longint'(PENDING_DEPTH),
                                longint'(pending_count()));
            else
                store_expected(predicted);
            requests_sent++;
        end
        else
        begin
            requests_dropped++;
        end
    endtask

    // Stops offering requests and waits until every predicted result has come
    // back, then lets the core settle in case a dropped request is in flight.
    task automatic wait_for_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_count() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE)
            @(negedge clk);
    endtask

    task automatic write_window_length(input logic [WINDOW_W-1:0] value);
        wait_for_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_window = value;
    endtask

    // Extremes of the sample field at the reset window of five, warm-up of a ring
    // and its full window, truncation toward zero and the dropped quantity code.
    task automatic test_reset_window_extremes();
        repeat (6)
            send_request(4'd0, QTY_POSITION, 32'h7FFF_FFFF);
        repeat (6)
            send_request(4'd15, QTY_EFFORT, 32'h8000_0000);
        send_request(4'd3, QTY_VELOCITY, 32'hFFFF_FFFD);
        send_request(4'd3, QTY_VELOCITY, 32'h0000_0000);
        send_request(4'd3, QTY_VELOCITY, 32'h0000_0001);
        send_request(4'd5, QTY_UNUSED, 32'h1234_5678);
        send_request(4'd15, QTY_UNUSED, 32'hFFFF_FFFF);
        send_request(4'd15, QTY_POSITION, 32'h0001_0000);
        send_request(4'd0, QTY_EFFORT, 32'hFFFF_0000);
        send_request(4'd10, QTY_VELOCITY, 32'h5555_AAAA);
    endtask

    // Window zero behaves as one; then the window shrinks below the fill of a
    // channel that is already full, which must keep its larger fill.
    task automatic test_window_edges();
        int k;
        write_window_length(6'd0);
        for (k = 0; k < 3; k++)
            send_request(4'd2, QTY_POSITION, pick_sample());
        write_window_length(6'd1);
        for (k = 0; k < 3; k++)
            send_request(4'd0, QTY_POSITION, pick_sample());
        send_request(4'd15, QTY_EFFORT, 32'h7FFF_FFFF);
    endtask

    // Phases of random requests, each under its own window. Most requests go to
    // a few busy channels so their rings fill, wrap and later see smaller windows.
    task automatic test_random_windows();
        logic [WINDOW_W-1:0] phase_window [RANDOM_PHASES];
        int phase;
        int accepted;
        int pick;
        logic [JOINT_W-1:0] joint;
        logic [QTY_W-1:0] quantity;
        phase_window[0] = 6'd63;
        phase_window[1] = 6'd3;
        phase_window[2] = 6'd32;
        phase_window[3] = 6'd0;
        phase_window[4] = WINDOW_W'($urandom_range(2, 31));
        phase_window[5] = 6'd33;
        phase_window[6] = 6'd1;
        phase_window[7] = WINDOW_W'($urandom_range(0, 63));
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_window_length(phase_window[phase]);
            accepted = 0;
            while (accepted < PHASE_REQUESTS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    joint = hot_joint[pick % HOT_CHANNELS];
                    quantity = hot_quantity[pick % HOT_CHANNELS];
                end
                else
                begin
                    joint = JOINT_W'($urandom);
                    quantity = QTY_W'($urandom_range(0, 2));
                    if (pick >= 95)
                        quantity = QTY_UNUSED;
                end
                send_request(joint, quantity, pick_sample());
                if (quantity != QTY_UNUSED)
                    accepted++;
            end
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so
    // the output register fills and the core stops taking requests. Then the
    // sender pauses until every result is back.
    task automatic test_receiver_hold_off();
        int k;
        wait_for_idle();
        sender_no_gaps = 1'b1;
        receiver_hold_cycles = 400;
        for (k = 0; k < 12; k++)
            send_request(hot_joint[k % HOT_CHANNELS], hot_quantity[k % HOT_CHANNELS],
                         pick_sample());
        sender_no_gaps = 1'b0;
        wait_for_idle();
    endtask

    // A stretch with neither side idling.
    task automatic test_back_to_back();
        int k;
        write_window_length(6'd32);
        sender_no_gaps = 1'b1;
        receiver_no_gaps = 1'b1;
        for (k = 0; k < 60; k++)
            send_request(JOINT_W'($urandom), QTY_W'($urandom_range(0, 2)), pick_sample());
        sender_no_gaps = 1'b0;
        receiver_no_gaps = 1'b0;
    endtask

    // Checks every result that the receiver accepts against the oldest prediction.
    always @(posedge clk)
    begin
        average_result_t predicted;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_count() == 0)
            begin
                report_mismatch("result with nothing pending", 0, longint'(m_tdata));
            end
            else
            begin
                predicted = take_expected();
                if (m_tuser[JOINT_W-1:0] !== predicted.joint)
                    report_mismatch("joint", longint'(predicted.joint),
                                    longint'(m_tuser[JOINT_W-1:0]));
                if (m_tuser[USER_W-1:JOINT_W] !== predicted.quantity)
                    report_mismatch("quantity", longint'(predicted.quantity),
                                    longint'(m_tuser[USER_W-1:JOINT_W]));
                if (m_tdata !== predicted.average)
                    report_mismatch("average", longint'(unsigned'(predicted.average)),
                                    longint'(m_tdata));
                averages_checked++;
            end
        end
    end

    // Receiver: random stalls, an occasional long hold-off, or none at all.
    initial
    begin
        int span;
        m_tready = 1'b0;
        forever
        begin
            if (receiver_hold_cycles > 0)
            begin
                span = receiver_hold_cycles;
                receiver_hold_cycles = 0;
                repeat (span)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            else
            begin
                span = receiver_no_gaps ? 0 : idle_gap();
                repeat (span)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
                @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int k;
        int ch;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pending_head = 0;
        pending_tail = 0;
        error_count = 0;
        requests_sent = 0;
        requests_dropped = 0;
        averages_checked = 0;
        receiver_hold_cycles = 0;
        sender_no_gaps = 1'b0;
        receiver_no_gaps = 1'b0;
        shadow_window = WINDOW_LENGTH_RESET;
        for (ch = 0; ch < CHANNELS; ch++)
        begin
            shadow_sum[ch] = 0;
            shadow_fill[ch] = 0;
            shadow_slot[ch] = 0;
        end
        for (k = 0; k < HOT_CHANNELS; k++)
        begin
            hot_joint[k] = JOINT_W'($urandom);
            hot_quantity[k] = QTY_W'(k);
        end
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;

        test_reset_window_extremes();
        test_window_edges();
        test_random_windows();
        test_receiver_hold_off();
        test_back_to_back();
        wait_for_idle();

        $display("covered windows 0, 1, 3, 32, 33, 63 and random, with ring wrap and shrink");
        $display("%0d averages checked from %0d requests, %0d dropped requests",
                 averages_checked, requests_sent, requests_dropped);
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("status: fail");
        end
        $finish;
    end

    // Far beyond the slowest correct run, including every stall and hold-off.
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still pending", pending_count());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mma_pkg.sv
rtl/core/mma_ram.sv
rtl/core/mma_div.sv
rtl/core/multichannel_moving_average_core.sv
tb/sv/tb_top.sv
